// ===== rtl/mbws_pkg.sv =====
`default_nettype none

package mbws_pkg;

  localparam int unsigned NUM_ELEM = 4;
  localparam int unsigned MAX_SNAP = 1024;
  localparam int unsigned SNAP_W   = 11;

  // covariance rows at 0..15 (row*4+col), cross-correlation / weights at 16..19
  localparam int unsigned MEM_DEPTH = 20;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned WORD_W    = 2 * ACC_W;

  localparam logic [31:0] DIAG_LOAD_RST = 32'd10737418;

  typedef enum logic {
    REG_DIAG_LOAD   = 1'b0,
    REG_SOLVER_MODE = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/mmse_beamform_weight_solver.sv =====
// MMSE beamforming weight solver for a four-element array.
// Input channel (in_valid/in_ready): one snapshot of four complex Q1.15
// samples plus the complex training symbol. Each item updates the 4x4
// covariance and the cross-correlation held in a 20-word memory, one word
// per read/write pair, set by the single write port of that memory; the
// next item is taken only after all 20 words. After 1024 snapshots further
// items are taken but not accumulated.
// An item with in_snap_last set starts the solve (with solver mode set it
// goes to the clearing sweep instead): a max scan and scaling pass,
// Gaussian elimination with a shared 63-step divider (20 updates) and back
// substitution (4 divisions plus 6 products). Four weights then leave on
// the output channel (out_valid/out_ready), one at a time, each held until
// taken; a stalled receiver holds the block. A sweep over all 20 words
// then clears the memory before the next item is accepted.
// Reset (rst_n low, synchronous) restores the registers and starts the
// same clearing sweep; configuration writes (cfg_we) are taken at
// any time and must come only while the block is idle.
`default_nettype none

module mmse_beamform_weight_solver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_elem0_re,
  input  wire logic signed [15:0] in_elem0_im,
  input  wire logic signed [15:0] in_elem1_re,
  input  wire logic signed [15:0] in_elem1_im,
  input  wire logic signed [15:0] in_elem2_re,
  input  wire logic signed [15:0] in_elem2_im,
  input  wire logic signed [15:0] in_elem3_re,
  input  wire logic signed [15:0] in_elem3_im,
  input  wire logic signed [15:0] in_ref_re,
  input  wire logic signed [15:0] in_ref_im,
  input  wire logic               in_snap_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_weight_index,
  output logic signed [31:0]      out_weight_re,
  output logic signed [31:0]      out_weight_im,
  output logic                    out_weight_last
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ACC_RD, S_ACC_WR, S_POST,
    S_MAX_RD, S_MAX_EV, S_SHINIT, S_SHIFT, S_SCL_RD, S_SCL_WR,
    S_PIV_RD, S_PIV_EV, S_ROW_RD, S_ROW_EV, S_EL_RD,
    S_MUL, S_SUM, S_DIVLD, S_DIV, S_EL_WR,
    S_BS_RD0, S_BS_INIT, S_BS_RD, S_BS_WR,
    S_OUT_RD, S_OUT_EV, S_OUT_WAIT
  } state_t;

  localparam int unsigned AW = mbws_pkg::ADDR_W;
  localparam int unsigned AV = mbws_pkg::ACC_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(mbws_pkg::MEM_DEPTH - 1);
  localparam logic [48:0] TH29 = 49'd1 << 29;
  localparam logic [48:0] TH28 = 49'd1 << 28;
  localparam logic signed [65:0] LIM30 = 66'sd1 <<< 30;
  localparam logic signed [65:0] LIM61 = 66'sd1 <<< 61;
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  logic [mbws_pkg::WORD_W-1:0] mem [mbws_pkg::MEM_DEPTH];
  logic [mbws_pkg::WORD_W-1:0] rd0_r, rd1_r, mem_wd;
  logic [AW-1:0]               mem_ra0, mem_ra1, mem_wa;
  logic                        mem_we;

  state_t state_r;
  logic [AW-1:0]  cnt_r;
  logic [mbws_pkg::SNAP_W-1:0] snap_r;
  logic [31:0]    diag_r;
  logic           mode_r;
  logic signed [15:0] xr_r [4];
  logic signed [15:0] xi_r [4];
  logic signed [15:0] sr_r, si_r;
  logic           last_r;
  logic [48:0]    mx_r, sh_r;
  logic           down_r, zero_r;
  logic [5:0]     s_r;
  logic [1:0]     k_r, i_r, oi_r;
  logic [2:0]     jb_r;
  logic           bs_r;
  logic [30:0]    d_r [4];
  logic signed [31:0] m_re_r, m_im_r, tgt_re_r, tgt_im_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [63:0] n_re_r, n_im_r;
  logic [62:0]    dq_re_r, dq_im_r;
  logic [31:0]    rem_re_r, rem_im_r;
  logic           neg_re_r, neg_im_r;
  logic [5:0]     dcnt_r;

  // accumulate datapath
  logic [1:0]         acc_i;
  logic signed [15:0] u_re, u_im, v_re, v_im;
  logic signed [AV-1:0] acc_re, acc_im;

  // scan / scale datapath
  logic               is_diag;
  logic signed [48:0] w_re, w_im, sc_re, sc_im;
  logic [48:0]        abs_re, abs_im;

  // products and divider
  logic signed [31:0] ma_re, ma_im, mb_re, mb_im;
  logic signed [65:0] pr66, pi66, dr66, di66;
  logic [31:0]        rsh_re, rsh_im, dvs;
  logic               ge_re, ge_im;
  logic signed [63:0] q_re, q_im;
  logic signed [65:0] e_re, e_im;
  logic signed [65:0] wq_re, wq_im, nwi;
  logic signed [31:0] rd0_im32;

  function automatic logic signed [65:0] clamp66(input logic signed [65:0] v,
                                                 input logic signed [65:0] lim);
    logic signed [65:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > MAX32) r = MAX32;
    if (v < MIN32) r = MIN32;
    return r[31:0];
  endfunction

  function automatic logic [48:0] abs49(input logic signed [48:0] v);
    logic signed [48:0] r;
    r = (v < 0) ? -v : v;
    return r;
  endfunction

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    acc_i = (cnt_r < AW'(16)) ? cnt_r[3:2] : cnt_r[1:0];
    u_re  = xr_r[acc_i];
    u_im  = xi_r[acc_i];
    v_re  = (cnt_r < AW'(16)) ? xr_r[cnt_r[1:0]] : sr_r;
    v_im  = (cnt_r < AW'(16)) ? xi_r[cnt_r[1:0]] : si_r;
    acc_re = $signed(rd0_r[2*AV-1:AV]) + AV'(u_re * v_re) + AV'(u_im * v_im);
    acc_im = $signed(rd0_r[AV-1:0]) + AV'(u_im * v_re) - AV'(u_re * v_im);

    is_diag = (cnt_r < AW'(16)) && (cnt_r[3:2] == cnt_r[1:0]);
    w_re = 49'($signed(rd0_r[2*AV-1:AV])) + (is_diag ? $signed({17'd0, diag_r}) : 49'sd0);
    w_im = 49'($signed(rd0_r[AV-1:0]));
    abs_re = abs49(w_re);
    abs_im = abs49(w_im);
    sc_re = down_r ? (w_re >>> s_r) : (w_re <<< s_r);
    sc_im = down_r ? (w_im >>> s_r) : (w_im <<< s_r);

    ma_re = bs_r ? $signed(rd0_r[AV+31:AV]) : m_re_r;
    ma_im = bs_r ? $signed(rd0_r[31:0]) : m_im_r;
    mb_re = bs_r ? $signed(rd1_r[AV+31:AV]) : $signed(rd0_r[AV+31:AV]);
    mb_im = bs_r ? $signed(rd1_r[31:0]) : $signed(rd0_r[31:0]);

    pr66 = 66'(p_rr_r) - 66'(p_ii_r);
    pi66 = 66'(p_ri_r) + 66'(p_ir_r);
    dr66 = clamp66(66'(n_re_r) - pr66, LIM61);
    di66 = clamp66(66'(n_im_r) - pi66, LIM61);

    dvs    = {1'b0, d_r[k_r]};
    rsh_re = {rem_re_r[30:0], dq_re_r[62]};
    rsh_im = {rem_im_r[30:0], dq_im_r[62]};
    ge_re  = rsh_re >= dvs;
    ge_im  = rsh_im >= dvs;

    q_re = neg_re_r ? -$signed({1'b0, dq_re_r}) : $signed({1'b0, dq_re_r});
    q_im = neg_im_r ? -$signed({1'b0, dq_im_r}) : $signed({1'b0, dq_im_r});
    e_re = clamp66(66'(tgt_re_r) - 66'(q_re), LIM30);
    e_im = clamp66(66'(tgt_im_r) - 66'(q_im), LIM30);
    wq_re = 66'(q_re);
    wq_im = 66'(q_im);

    rd0_im32 = $signed(rd0_r[31:0]);
    nwi = -66'(rd0_im32);
  end

  always_comb begin
    mem_ra0 = cnt_r;
    mem_ra1 = cnt_r;
    mem_we  = 1'b0;
    mem_wa  = cnt_r;
    mem_wd  = '0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_ACC_WR: begin
        mem_we = 1'b1;
        mem_wd = {acc_re, acc_im};
      end
      S_SCL_WR: begin
        mem_we = 1'b1;
        mem_wd = {sc_re[AV-1:0], sc_im[AV-1:0]};
      end
      S_PIV_RD: mem_ra0 = {1'b0, k_r, k_r};
      S_ROW_RD: mem_ra0 = {1'b0, i_r, k_r};
      S_EL_RD: begin
        mem_ra0 = jb_r[2] ? {3'b100, k_r} : {1'b0, k_r, jb_r[1:0]};
        mem_ra1 = jb_r[2] ? {3'b100, i_r} : {1'b0, i_r, jb_r[1:0]};
      end
      S_EL_WR: begin
        mem_we = 1'b1;
        mem_wa = jb_r[2] ? {3'b100, i_r} : {1'b0, i_r, jb_r[1:0]};
        mem_wd = {AV'(e_re), AV'(e_im)};
      end
      S_BS_RD0: mem_ra0 = {3'b100, k_r};
      S_BS_RD: begin
        mem_ra0 = {1'b0, k_r, jb_r[1:0]};
        mem_ra1 = {3'b100, jb_r[1:0]};
      end
      S_BS_WR: begin
        mem_we = 1'b1;
        mem_wa = {3'b100, k_r};
        mem_wd = {AV'(sat32(wq_re)), AV'(sat32(wq_im))};
      end
      S_OUT_RD: mem_ra0 = {3'b100, oi_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd0_r <= mem[mem_ra0];
    rd1_r <= mem[mem_ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      snap_r    <= '0;
      diag_r    <= mbws_pkg::DIAG_LOAD_RST;
      mode_r    <= 1'b0;
      out_valid <= 1'b0;
      zero_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (mbws_pkg::cfg_reg_t'(cfg_addr))
          mbws_pkg::REG_DIAG_LOAD:   diag_r <= cfg_wdata;
          mbws_pkg::REG_SOLVER_MODE: mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_ADDR) begin
            cnt_r   <= '0;
            snap_r  <= '0;
            zero_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            xr_r[0] <= in_elem0_re;
            xi_r[0] <= in_elem0_im;
            xr_r[1] <= in_elem1_re;
            xi_r[1] <= in_elem1_im;
            xr_r[2] <= in_elem2_re;
            xi_r[2] <= in_elem2_im;
            xr_r[3] <= in_elem3_re;
            xi_r[3] <= in_elem3_im;
            sr_r    <= in_ref_re;
            si_r    <= in_ref_im;
            last_r  <= in_snap_last;
            cnt_r   <= '0;
            state_r <= (snap_r < mbws_pkg::SNAP_W'(mbws_pkg::MAX_SNAP)) ? S_ACC_RD : S_POST;
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= S_ACC_RD;
          if (cnt_r == LAST_ADDR) begin
            snap_r  <= snap_r + 1'b1;
            state_r <= S_POST;
          end
        end
        S_POST: begin
          cnt_r <= '0;
          mx_r  <= '0;
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (mode_r) begin
            state_r <= S_CLR;
          end else begin
            state_r <= S_MAX_RD;
          end
        end
        S_MAX_RD: state_r <= S_MAX_EV;
        S_MAX_EV: begin
          if (abs_re > mx_r && abs_re >= abs_im) begin
            mx_r <= abs_re;
          end else if (abs_im > mx_r) begin
            mx_r <= abs_im;
          end
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == LAST_ADDR) ? S_SHINIT : S_MAX_RD;
        end
        S_SHINIT: begin
          cnt_r  <= '0;
          sh_r   <= mx_r;
          s_r    <= '0;
          down_r <= mx_r >= TH29;
          oi_r   <= '0;
          if (mx_r == '0) begin
            zero_r  <= 1'b1;
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (down_r && sh_r >= TH29) begin
            sh_r <= sh_r >> 1;
            s_r  <= s_r + 1'b1;
          end else if (!down_r && sh_r < TH28) begin
            sh_r <= sh_r << 1;
            s_r  <= s_r + 1'b1;
          end else begin
            state_r <= S_SCL_RD;
          end
        end
        S_SCL_RD: state_r <= S_SCL_WR;
        S_SCL_WR: begin
          cnt_r   <= cnt_r + 1'b1;
          k_r     <= '0;
          state_r <= (cnt_r == LAST_ADDR) ? S_PIV_RD : S_SCL_RD;
        end
        S_PIV_RD: state_r <= S_PIV_EV;
        S_PIV_EV: begin
          d_r[k_r] <= ($signed(rd0_r[AV+31:AV]) < 32'sd1) ? 31'd1 : rd0_r[AV+30:AV];
          i_r      <= k_r + 1'b1;
          state_r  <= (k_r == 2'd3) ? S_BS_RD0 : S_ROW_RD;
        end
        S_ROW_RD: state_r <= S_ROW_EV;
        S_ROW_EV: begin
          m_re_r  <= $signed(rd0_r[AV+31:AV]);
          m_im_r  <= $signed(rd0_r[31:0]);
          jb_r    <= {1'b0, k_r} + 3'd1;
          state_r <= S_EL_RD;
        end
        S_EL_RD: begin
          bs_r    <= 1'b0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          p_rr_r   <= ma_re * mb_re;
          p_ii_r   <= ma_im * mb_im;
          p_ri_r   <= ma_re * mb_im;
          p_ir_r   <= ma_im * mb_re;
          tgt_re_r <= $signed(rd1_r[AV+31:AV]);
          tgt_im_r <= $signed(rd1_r[31:0]);
          state_r  <= S_SUM;
        end
        S_SUM: begin
          if (!bs_r) begin
            n_re_r  <= pr66[63:0];
            n_im_r  <= pi66[63:0];
            state_r <= S_DIVLD;
          end else begin
            n_re_r <= dr66[63:0];
            n_im_r <= di66[63:0];
            jb_r   <= jb_r + 1'b1;
            state_r <= (jb_r == 3'd3) ? S_DIVLD : S_BS_RD;
          end
        end
        S_DIVLD: begin
          neg_re_r <= n_re_r < 0;
          neg_im_r <= n_im_r < 0;
          dq_re_r  <= (n_re_r < 0) ? 63'(-n_re_r) : n_re_r[62:0];
          dq_im_r  <= (n_im_r < 0) ? 63'(-n_im_r) : n_im_r[62:0];
          rem_re_r <= '0;
          rem_im_r <= '0;
          dcnt_r   <= '0;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          rem_re_r <= ge_re ? rsh_re - dvs : rsh_re;
          rem_im_r <= ge_im ? rsh_im - dvs : rsh_im;
          dq_re_r  <= {dq_re_r[61:0], ge_re};
          dq_im_r  <= {dq_im_r[61:0], ge_im};
          dcnt_r   <= dcnt_r + 1'b1;
          if (dcnt_r == 6'd62) begin
            state_r <= bs_r ? S_BS_WR : S_EL_WR;
          end
        end
        S_EL_WR: begin
          if (!jb_r[2]) begin
            jb_r    <= jb_r + 1'b1;
            state_r <= S_EL_RD;
          end else if (i_r != 2'd3) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ROW_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PIV_RD;
          end
        end
        S_BS_RD0: begin
          bs_r    <= 1'b1;
          state_r <= S_BS_INIT;
        end
        S_BS_INIT: begin
          n_re_r  <= 64'($signed(rd0_r[AV+31:AV])) <<< 24;
          n_im_r  <= 64'($signed(rd0_r[31:0])) <<< 24;
          jb_r    <= {1'b0, k_r} + 3'd1;
          state_r <= (k_r == 2'd3) ? S_DIVLD : S_BS_RD;
        end
        S_BS_RD: state_r <= S_MUL;
        S_BS_WR: begin
          oi_r <= '0;
          if (k_r == 2'd0) begin
            state_r <= S_OUT_RD;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= S_BS_RD0;
          end
        end
        S_OUT_RD: state_r <= S_OUT_EV;
        S_OUT_EV: begin
          out_valid        <= 1'b1;
          out_weight_index <= oi_r;
          out_weight_re    <= zero_r ? 32'sd0 : $signed(rd0_r[AV+31:AV]);
          out_weight_im    <= zero_r ? 32'sd0 : sat32(nwi);
          out_weight_last  <= (oi_r == 2'd3);
          state_r          <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            oi_r      <= oi_r + 1'b1;
            cnt_r     <= '0;
            state_r   <= (oi_r == 2'd3) ? S_CLR : S_OUT_RD;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

endmodule

`default_nettype wire
